### design/scf_pkg.sv
package scf_pkg;

    // Width of the value field; the root and the term recurrence are sized from it.
    localparam int VALUE_BITS = 31;
    localparam int TERM_BITS  = 17;
    localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2;
    localparam int SQ_BITS    = 2 * ROOT_BITS;
    localparam int SUM_BITS   = ROOT_BITS + 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [VALUE_BITS-1:0] value;
    } scf_in_t;

    typedef struct packed {
        logic [TERM_BITS-1:0] term;
        logic                 last;
        logic                 status;
    } scf_out_t;

    typedef enum logic [1:0] {
        SEL_ERROR,
        SEL_ROOT,
        SEL_TERM
    } scf_sel_t;

    typedef struct packed {
        logic     load_start;
        logic     sqrt_step;
        logic     store_root;
        logic     load_mul;
        logic     load_div1;
        logic     load_div2;
        logic     div_step;
        logic     store_rem;
        logic     load_out;
        scf_sel_t out_sel;
    } scf_cmd_t;

    typedef struct packed {
        logic command;
        logic value_zero;
        logic den_zero;
        logic quot_zero;
        logic exact;
        logic sqrt_last;
        logic div1_last;
        logic div2_last;
    } scf_status_t;

endpackage

### design/scf_datapath.sv
module scf_datapath
    import scf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scf_in_t     in_data,
    input  scf_cmd_t    cmd,
    output scf_status_t status,
    output scf_out_t    out_data
);

    logic [ROOT_BITS-1:0]  root_reg;
    logic [VALUE_BITS-1:0] number_reg;
    logic [SUM_BITS-1:0]   rem_term_reg;
    logic [VALUE_BITS-1:0] den_reg;

    logic [SQ_BITS-1:0]    x_reg;
    logic [SQ_BITS-1:0]    res_reg;
    logic [SQ_BITS-1:0]    bit_reg;

    logic [SQ_BITS-1:0]    sq_reg;
    logic [SUM_BITS-1:0]   sum_reg;

    logic [VALUE_BITS-1:0] div_rem_reg;
    logic [VALUE_BITS-1:0] div_q_reg;
    logic [VALUE_BITS-1:0] divisor_reg;
    logic [CNT_BITS-1:0]   cnt_reg;

    scf_out_t              out_reg;

    // Square root step, one result bit per cycle.
    logic [SQ_BITS:0]      trial;
    logic                  take;
    logic [SQ_BITS-1:0]    x_next;
    logic [SQ_BITS-1:0]    res_next;

    // Restoring division step, one quotient bit per cycle.
    logic [VALUE_BITS:0]   div_shift;
    logic                  div_ge;
    logic [VALUE_BITS-1:0] div_rem_next;
    logic [VALUE_BITS-1:0] div_q_next;

    logic [ROOT_BITS-1:0]  m_val;
    logic [SQ_BITS-1:0]    number_ext;
    logic [VALUE_BITS-1:0] diff_val;
    logic [VALUE_BITS-1:0] sum_ext;
    logic [VALUE_BITS:0]   twice_root;
    logic                  term_last;
    scf_out_t              out_next;

    always_comb
    begin
        trial    = {1'b0, res_reg} + {1'b0, bit_reg};
        take     = ({1'b0, x_reg} >= trial);
        x_next   = take ? SQ_BITS'({1'b0, x_reg} - trial) : x_reg;
        res_next = take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

        div_shift    = {div_rem_reg, div_q_reg[VALUE_BITS-1]};
        div_ge       = (div_shift >= {1'b0, divisor_reg});
        div_rem_next = div_ge ? VALUE_BITS'(div_shift - {1'b0, divisor_reg})
                              : div_shift[VALUE_BITS-1:0];
        div_q_next   = {div_q_reg[VALUE_BITS-2:0], div_ge};

        m_val = (rem_term_reg <= SUM_BITS'(root_reg))
              ? ROOT_BITS'(SUM_BITS'(root_reg) - rem_term_reg) : '0;

        number_ext = SQ_BITS'(number_reg);
        diff_val   = (number_ext >= sq_reg) ? VALUE_BITS'(number_ext - sq_reg) : '0;

        // The second dividend sits at the top so that fewer steps finish it.
        sum_ext = VALUE_BITS'(sum_reg) << (VALUE_BITS - SUM_BITS);

        twice_root = (VALUE_BITS + 1)'({root_reg, 1'b0});
        term_last  = ({1'b0, div_q_reg} == twice_root);

        out_next = '0;
        case (cmd.out_sel)
            SEL_ROOT:
            begin
                out_next.term   = TERM_BITS'(root_reg);
                out_next.last   = (x_reg == '0);
                out_next.status = STATUS_OK;
            end
            SEL_TERM:
            begin
                out_next.term   = TERM_BITS'(div_q_reg);
                out_next.last   = term_last;
                out_next.status = STATUS_OK;
            end
            default:
            begin
                out_next.term   = '0;
                out_next.last   = 1'b0;
                out_next.status = STATUS_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg     <= '0;
            number_reg   <= '0;
            rem_term_reg <= '0;
            den_reg      <= VALUE_BITS'(1);
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                number_reg   <= in_data.value;
                rem_term_reg <= '0;
                den_reg      <= VALUE_BITS'(1);
            end
            if (cmd.store_root)
            begin
                root_reg <= res_next[ROOT_BITS-1:0];
            end
            if (cmd.load_div2)
            begin
                den_reg <= div_q_reg;
            end
            if (cmd.store_rem)
            begin
                rem_term_reg <= div_rem_next[SUM_BITS-1:0];
            end
            if (cmd.load_start || cmd.load_div1 || cmd.load_div2)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sqrt_step || cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            x_reg   <= SQ_BITS'(in_data.value);
            res_reg <= '0;
            bit_reg <= SQ_BITS'(1) << (SQ_BITS - 2);
        end
        else if (cmd.sqrt_step)
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.load_mul)
        begin
            sq_reg  <= SQ_BITS'(m_val) * SQ_BITS'(m_val);
            sum_reg <= SUM_BITS'(root_reg) + SUM_BITS'(m_val);
        end

        if (cmd.load_div1)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= diff_val;
            divisor_reg <= den_reg;
        end
        else if (cmd.load_div2)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= sum_ext;
            divisor_reg <= div_q_reg;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
        end

        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign status.command    = in_data.command;
    assign status.value_zero = (in_data.value == '0);
    assign status.den_zero   = (den_reg == '0);
    assign status.quot_zero  = (div_q_reg == '0);
    assign status.exact      = (x_reg == '0);
    assign status.sqrt_last  = (cnt_reg == CNT_BITS'(ROOT_BITS - 1));
    assign status.div1_last  = (cnt_reg == CNT_BITS'(VALUE_BITS - 1));
    assign status.div2_last  = (cnt_reg == CNT_BITS'(SUM_BITS - 1));

    assign out_data = out_reg;

endmodule

### design/scf_controller.sv
module scf_controller
    import scf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  scf_status_t status,
    output scf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIFF,
        ST_DIV1,
        ST_CHECK,
        ST_DIV2,
        ST_FINISH
    } state_t;

    state_t   state_reg, state_next;
    logic     active_reg, active_next;
    logic     out_valid_reg, out_valid_next;
    scf_sel_t sel_reg, sel_next;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        cmd            = '0;
        cmd.out_sel    = sel_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.command == CMD_START)
                    begin
                        if (status.value_zero)
                        begin
                            active_next = 1'b0;
                            sel_next    = SEL_ERROR;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            cmd.load_start = 1'b1;
                            state_next     = ST_SQRT;
                        end
                    end
                    else if (!active_reg || status.den_zero)
                    begin
                        sel_next   = SEL_ERROR;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.load_mul = 1'b1;
                        state_next   = ST_DIFF;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    cmd.store_root = 1'b1;
                    sel_next       = SEL_ROOT;
                    state_next     = ST_FINISH;
                end
            end
            ST_DIFF:
            begin
                cmd.load_div1 = 1'b1;
                state_next    = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div1_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.quot_zero)
                begin
                    active_next = 1'b0;
                    sel_next    = SEL_ERROR;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.load_div2 = 1'b1;
                    state_next    = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div2_last)
                begin
                    cmd.store_rem = 1'b1;
                    sel_next      = SEL_TERM;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (sel_reg == SEL_ROOT)
                    begin
                        active_next = !status.exact;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sel_reg       <= SEL_ERROR;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### design/sqrt_continued_fraction.sv
// Continued fraction expansion of a square root. A start transfer (command 0) loads a
// positive value, computes its integer square root bit by bit and returns it as the
// first term, marked last when the value is a perfect square. Each next transfer
// (command 1) returns the following partial quotient; the term equal to twice the root
// is marked last, and further next transfers repeat the period. A start with zero, or a
// next with no expansion running, returns error status with term zero. One item is
// worked on at a time: a start runs the square root unit (one result bit per cycle),
// and a next runs the shared restoring divider, which does a full-width division and
// then one that is one bit wider than the root.
// A result held in the output register does not block the next input transfer.
module sqrt_continued_fraction
    import scf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  scf_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output scf_out_t out_data
);

    scf_cmd_t    cmd;
    scf_status_t status;

    scf_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    scf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
